// ===== src/ddo_pkg.sv =====
// shared types, constants and functions for the differential drive odometry block
`default_nettype none

package ddo_pkg;

    localparam int PosW        = 32;
    localparam int DeltaW      = 33;
    localparam int DiffW       = 34;
    localparam int AxisW       = 20;
    localparam int ThrW        = 16;
    localparam int CfgIdxW     = 8;
    localparam int CfgDataW    = 32;
    localparam int DivW        = 62;
    localparam int CordW       = 34;
    localparam int ProdW       = 2 * CordW;
    localparam int CordicSteps = 30;
    localparam int StepW       = 5;
    localparam int YawShift    = 28;
    localparam int QueueDepthDefault = 2;

    localparam logic [AxisW-1:0] AXIS_RESET = 20'd30147;
    localparam logic [ThrW-1:0]  THR_RESET  = 16'd66;

    localparam logic [CfgIdxW-1:0] CFG_AXIS_LENGTH        = 8'd0;
    localparam logic [CfgIdxW-1:0] CFG_STRAIGHT_THRESHOLD = 8'd1;

    localparam logic [DivW-1:0]         TWO_PI_DIV  = 62'd3373259426;
    localparam logic signed [CordW-1:0] TWO_PI_Q29  = 34'sd3373259426;
    localparam logic signed [CordW-1:0] PI_Q29      = 34'sd1686629713;
    localparam logic signed [CordW-1:0] HALF_PI_Q29 = 34'sd843314857;
    localparam logic signed [CordW-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [CordW-1:0] Q30_ONE     = 34'sd1073741824;
    // 2^62 / two pi in Q29, rounded down so the quotient estimate never overshoots
    localparam logic signed [CordW-1:0] RECIP_2PI   = 34'sd1367130550;

    typedef enum logic [1:0] {
        KIND_INCOMPLETE,
        KIND_STRAIGHT,
        KIND_ARC
    } ddo_kind_t;

    typedef struct packed {
        ddo_kind_t                 kind;
        logic signed [DeltaW-1:0]  dl;
        logic signed [DeltaW-1:0]  dr;
    } ddo_entry_t;

    typedef struct packed {
        logic            start;
        logic [DivW-1:0] dividend;
        logic [DivW-1:0] divisor;
    } ddo_div_req_t;

    typedef struct packed {
        logic            busy;
        logic [DivW-1:0] quot;
    } ddo_div_rsp_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_YAW,
        B_RCP,
        B_QM,
        B_SUB,
        B_MOD,
        B_CORDIC,
        B_FIX,
        B_MSC,
        B_MSS,
        B_RAD,
        B_MXH,
        B_MXL,
        B_MYH,
        B_MYL,
        B_FIN
    } ddo_state_t;

    // atan(2^-i) in Q30
    function automatic logic [CordW-1:0] atan_q30(input logic [StepW-1:0] i);
        logic [CordW-1:0] v;
        case (i)
            5'd0:  v = 34'd843314856;
            5'd1:  v = 34'd497837829;
            5'd2:  v = 34'd263043836;
            5'd3:  v = 34'd133525158;
            5'd4:  v = 34'd67021686;
            5'd5:  v = 34'd33543515;
            5'd6:  v = 34'd16775850;
            5'd7:  v = 34'd8388437;
            5'd8:  v = 34'd4194282;
            5'd9:  v = 34'd2097149;
            5'd10: v = 34'd1048575;
            5'd11: v = 34'd524287;
            5'd12: v = 34'd262143;
            5'd13: v = 34'd131071;
            5'd14: v = 34'd65535;
            5'd15: v = 34'd32767;
            5'd16: v = 34'd16383;
            5'd17: v = 34'd8191;
            5'd18: v = 34'd4095;
            5'd19: v = 34'd2047;
            5'd20: v = 34'd1023;
            5'd21: v = 34'd511;
            5'd22: v = 34'd255;
            5'd23: v = 34'd127;
            5'd24: v = 34'd63;
            5'd25: v = 34'd31;
            5'd26: v = 34'd15;
            5'd27: v = 34'd8;
            5'd28: v = 34'd4;
            5'd29: v = 34'd2;
            default: v = '0;
        endcase
        return v;
    endfunction

    // magnitude with sign applied, saturated to 32 bit signed
    function automatic logic [PosW-1:0] sat_mag(input logic [63:0] r, input logic neg);
        logic [PosW-1:0] v;
        if (neg) begin
            v = (r > 64'h0000_0000_8000_0000) ? 32'h8000_0000 : (32'd0 - r[PosW-1:0]);
        end else begin
            v = (r > 64'h0000_0000_7FFF_FFFF) ? 32'h7FFF_FFFF : r[PosW-1:0];
        end
        return v;
    endfunction

    function automatic logic [PosW-1:0] clamp_q30(input logic signed [CordW-1:0] v);
        logic signed [CordW-1:0] c;
        if (v > Q30_ONE) begin
            c = Q30_ONE;
        end else if (v < -Q30_ONE) begin
            c = -Q30_ONE;
        end else begin
            c = v;
        end
        return c[PosW-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== src/ddo_front.sv =====
// front end: tread deltas, sample history and step classification
`default_nettype none

module ddo_front (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic signed [ddo_pkg::PosW-1:0] s_left_position,
    input  wire logic                          s_left_present,
    input  wire logic signed [ddo_pkg::PosW-1:0] s_right_position,
    input  wire logic                          s_right_present,
    input  wire logic [ddo_pkg::ThrW-1:0]      straight_threshold,
    input  wire logic                          q_full,
    output logic                               q_push,
    output ddo_pkg::ddo_entry_t                q_entry
);
    import ddo_pkg::*;

    logic signed [PosW-1:0]   prev_left_reg, prev_left_next;
    logic signed [PosW-1:0]   prev_right_reg, prev_right_next;
    logic                     first_reg, first_next;
    logic signed [DeltaW-1:0] dl, dr;
    logic signed [DiffW-1:0]  diff;
    logic [DiffW-1:0]         adiff;
    logic                     accept;

    assign s_ready = !q_full;
    assign accept  = s_valid && !q_full;
    assign q_push  = accept;

    always_comb begin
        dl = '0;
        dr = '0;
        if (s_left_present && !first_reg) begin
            dl = DeltaW'(s_left_position) - DeltaW'(prev_left_reg);
        end
        if (s_right_present && !first_reg) begin
            dr = DeltaW'(s_right_position) - DeltaW'(prev_right_reg);
        end
        diff  = DiffW'(dr) - DiffW'(dl);
        adiff = diff[DiffW-1] ? -diff : diff;
        q_entry.dl = dl;
        q_entry.dr = dr;
        if (!(s_left_present && s_right_present)) begin
            q_entry.kind = KIND_INCOMPLETE;
        end else if (adiff > DiffW'(straight_threshold)) begin
            q_entry.kind = KIND_ARC;
        end else begin
            q_entry.kind = KIND_STRAIGHT;
        end
    end

    always_comb begin
        prev_left_next  = prev_left_reg;
        prev_right_next = prev_right_reg;
        first_next      = first_reg;
        if (accept) begin
            if (s_left_present) begin
                prev_left_next = s_left_position;
            end
            if (s_right_present) begin
                prev_right_next = s_right_position;
            end
            first_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_left_reg  <= '0;
            prev_right_reg <= '0;
            first_reg      <= 1'b1;
        end else begin
            prev_left_reg  <= prev_left_next;
            prev_right_reg <= prev_right_next;
            first_reg      <= first_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/ddo_fifo.sv =====
// short queue of classified steps between front and back
`default_nettype none

module ddo_fifo #(
    parameter int DEPTH = ddo_pkg::QueueDepthDefault
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                push,
    input  wire ddo_pkg::ddo_entry_t entry_in,
    output logic                     full,
    output logic                     valid,
    input  wire logic                pop,
    output ddo_pkg::ddo_entry_t      entry_out
);
    import ddo_pkg::*;

    localparam int PtrW = $clog2(DEPTH);
    localparam int CntW = $clog2(DEPTH + 1);

    ddo_entry_t       mem_reg [DEPTH];
    logic [PtrW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]  count_reg, count_next;
    logic             do_push, do_pop;

    assign full      = (count_reg == CntW'(DEPTH));
    assign valid     = (count_reg != '0);
    assign entry_out = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= entry_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/ddo_div.sv =====
// restoring unsigned divider, one quotient bit per cycle
`default_nettype none

module ddo_div (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire ddo_pkg::ddo_div_req_t req,
    output ddo_pkg::ddo_div_rsp_t      rsp
);
    import ddo_pkg::*;

    localparam int CntW = $clog2(DivW);

    logic            busy_reg, busy_next;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic [DivW-1:0] rem_reg, rem_next;
    logic [DivW-1:0] quot_reg, quot_next;
    logic [DivW-1:0] divisor_reg, divisor_next;
    logic [DivW:0]   shifted, trial;

    assign rsp.busy = busy_reg;
    assign rsp.quot = quot_reg;

    always_comb begin
        shifted      = {rem_reg, quot_reg[DivW-1]};
        trial        = shifted - {1'b0, divisor_reg};
        busy_next    = busy_reg;
        cnt_next     = cnt_reg;
        rem_next     = rem_reg;
        quot_next    = quot_reg;
        divisor_next = divisor_reg;
        if (req.start) begin
            busy_next    = 1'b1;
            cnt_next     = '0;
            rem_next     = '0;
            quot_next    = req.dividend;
            divisor_next = req.divisor;
        end else if (busy_reg) begin
            if (!trial[DivW]) begin
                rem_next  = trial[DivW-1:0];
                quot_next = {quot_reg[DivW-2:0], 1'b1};
            end else begin
                rem_next  = shifted[DivW-1:0];
                quot_next = {quot_reg[DivW-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CntW'(DivW - 1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg     <= rem_next;
        quot_reg    <= quot_next;
        divisor_reg <= divisor_next;
        cnt_reg     <= cnt_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/ddo_back.sv =====
// back end: arc math sequencer (divides, cordic, products) and result register
`default_nettype none

module ddo_back (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic [ddo_pkg::AxisW-1:0]       axis_eff,
    input  wire logic                            q_valid,
    input  wire ddo_pkg::ddo_entry_t             q_entry,
    output logic                                 q_pop,
    output ddo_pkg::ddo_div_req_t                div_req,
    input  wire ddo_pkg::ddo_div_rsp_t           div_rsp,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic signed [ddo_pkg::PosW-1:0]      m_move_x,
    output logic signed [ddo_pkg::PosW-1:0]      m_move_y,
    output logic signed [ddo_pkg::PosW-1:0]      m_rot_z,
    output logic signed [ddo_pkg::PosW-1:0]      m_rot_w,
    output logic                                 m_incomplete
);
    import ddo_pkg::*;

    ddo_state_t               state_reg, state_next;
    logic signed [DeltaW-1:0] dl_reg;
    logic                     yaw_neg_reg;
    logic [DivW-1:0]          yaw_mag_reg;
    logic [DivW-1:0]          mrem_reg;
    logic signed [CordW-1:0]  cx_reg, cy_reg, cz_reg;
    logic [StepW-1:0]         step_reg;
    logic                     flip_reg;
    logic signed [CordW-1:0]  s_reg, c_reg, sin_reg, omc_reg;
    logic [DivW-1:0]          rad_mag_reg;
    logic                     rad_neg_reg;
    logic signed [ProdW-1:0]  prod_reg;
    logic [63:0]              acc_reg;
    logic [PosW-1:0]          mx_arc_reg;
    logic                     m_valid_reg;
    logic signed [PosW-1:0]   mx_reg, my_reg, rz_reg, rw_reg;
    logic                     inc_reg;

    logic                     out_free;
    logic signed [DiffW-1:0]  e_diff;
    logic [DiffW-1:0]         e_adiff;
    logic signed [DiffW-1:0]  st_sum, st_half;
    logic [PosW-1:0]          st_x;
    logic [DeltaW-1:0]        dl_mag;
    logic signed [CordW-1:0]  r_mod, r_fold;
    logic                     flip_fold;
    logic signed [CordW-1:0]  dx, dy, atan_v;
    logic signed [DivW:0]     q_s, rad_s;
    logic signed [CordW-1:0]  sin_abs, omc_abs;
    logic signed [CordW-1:0]  mul_a, mul_b;
    logic [63:0]              sum_r;
    logic                     mul_en;

    assign out_free     = !m_valid_reg || m_ready;
    assign m_valid      = m_valid_reg;
    assign m_move_x     = mx_reg;
    assign m_move_y     = my_reg;
    assign m_rot_z      = rz_reg;
    assign m_rot_w      = rw_reg;
    assign m_incomplete = inc_reg;

    // datapath helpers
    always_comb begin
        e_diff  = DiffW'(q_entry.dr) - DiffW'(q_entry.dl);
        e_adiff = e_diff[DiffW-1] ? -e_diff : e_diff;
        st_sum  = DiffW'(q_entry.dl) + DiffW'(q_entry.dr);
        st_half = st_sum >>> 1;
        if (st_half > DiffW'(34'sh0_7FFF_FFFF)) begin
            st_x = 32'h7FFF_FFFF;
        end else if (st_half < -DiffW'(34'sh0_8000_0000)) begin
            st_x = 32'h8000_0000;
        end else begin
            st_x = st_half[PosW-1:0];
        end
        dl_mag = dl_reg[DeltaW-1] ? -dl_reg : dl_reg;

        // remainder carries the sign of the dividend, then fold into +-pi/2
        r_mod = $signed({2'b00, mrem_reg[PosW-1:0]});
        if (yaw_neg_reg) begin
            r_mod = -r_mod;
        end
        r_fold = r_mod;
        if (r_fold > PI_Q29) begin
            r_fold = r_fold - TWO_PI_Q29;
        end
        if (r_fold < -PI_Q29) begin
            r_fold = r_fold + TWO_PI_Q29;
        end
        flip_fold = 1'b0;
        if (r_fold > HALF_PI_Q29) begin
            r_fold    = r_fold - PI_Q29;
            flip_fold = 1'b1;
        end else if (r_fold < -HALF_PI_Q29) begin
            r_fold    = r_fold + PI_Q29;
            flip_fold = 1'b1;
        end

        dx     = cy_reg >>> step_reg;
        dy     = cx_reg >>> step_reg;
        atan_v = $signed(atan_q30(step_reg));

        q_s = $signed({1'b0, div_rsp.quot});
        if (dl_reg[DeltaW-1] != yaw_neg_reg) begin
            q_s = -q_s;
        end
        rad_s = q_s + $signed((DivW + 1)'(axis_eff >> 1));

        sin_abs = sin_reg[CordW-1] ? -sin_reg : sin_reg;
        omc_abs = omc_reg[CordW-1] ? -omc_reg : omc_reg;
        sum_r   = (acc_reg << 2) + (prod_reg[63:0] >> 30);
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE: begin
                if (q_valid && out_free && q_entry.kind == KIND_ARC) begin
                    state_next = B_YAW;
                end
            end
            B_YAW: begin
                if (!div_rsp.busy) begin
                    state_next = B_RCP;
                end
            end
            B_RCP: state_next = B_QM;
            B_QM:  state_next = B_SUB;
            B_SUB: state_next = B_MOD;
            B_MOD: begin
                if (mrem_reg < TWO_PI_DIV) begin
                    state_next = B_CORDIC;
                end
            end
            B_CORDIC: begin
                if (step_reg == StepW'(CordicSteps - 1)) begin
                    state_next = B_FIX;
                end
            end
            B_FIX: state_next = B_MSC;
            B_MSC: state_next = B_MSS;
            B_MSS: state_next = B_RAD;
            B_RAD: begin
                if (!div_rsp.busy) begin
                    state_next = B_MXH;
                end
            end
            B_MXH: state_next = B_MXL;
            B_MXL: state_next = B_MYH;
            B_MYH: state_next = B_MYL;
            B_MYL: state_next = B_FIN;
            B_FIN: begin
                if (out_free) begin
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    // control outputs: queue pop, divider requests, multiplier operands
    always_comb begin
        q_pop            = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = '0;
        mul_a            = '0;
        mul_b            = '0;
        mul_en           = 1'b0;
        case (state_reg)
            B_IDLE: begin
                q_pop = q_valid && out_free;
                if (q_valid && out_free && q_entry.kind == KIND_ARC) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = DivW'(e_adiff) << YawShift;
                    div_req.divisor  = DivW'(axis_eff);
                end
            end
            B_YAW: begin
                // radius divide runs while the angle is reduced and rotated
                if (!div_rsp.busy) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = DivW'(dl_mag) << YawShift;
                    div_req.divisor  = div_rsp.quot;
                end
            end
            B_RCP: begin
                // quotient estimate for the reduction by two pi
                mul_en = 1'b1;
                mul_a  = $signed({2'b00, yaw_mag_reg[DivW-1:30]});
                mul_b  = RECIP_2PI;
            end
            B_QM: begin
                mul_en = 1'b1;
                mul_a  = $signed({2'b00, prod_reg[63:32]});
                mul_b  = TWO_PI_Q29;
            end
            B_MSC: begin
                mul_en = 1'b1;
                mul_a  = s_reg;
                mul_b  = c_reg;
            end
            B_MSS: begin
                mul_en = 1'b1;
                mul_a  = s_reg;
                mul_b  = s_reg;
            end
            B_MXH: begin
                mul_en = 1'b1;
                mul_a  = $signed(CordW'(rad_mag_reg[DivW-1:32]));
                mul_b  = sin_abs;
            end
            B_MXL: begin
                mul_en = 1'b1;
                mul_a  = $signed(CordW'(rad_mag_reg[31:0]));
                mul_b  = sin_abs;
            end
            B_MYH: begin
                mul_en = 1'b1;
                mul_a  = $signed(CordW'(rad_mag_reg[DivW-1:32]));
                mul_b  = omc_abs;
            end
            B_MYL: begin
                mul_en = 1'b1;
                mul_a  = $signed(CordW'(rad_mag_reg[31:0]));
                mul_b  = omc_abs;
            end
            default: begin
                mul_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mul_en) begin
            prod_reg <= mul_a * mul_b;
        end
        case (state_reg)
            B_IDLE: begin
                if (q_valid && out_free) begin
                    dl_reg      <= q_entry.dl;
                    yaw_neg_reg <= e_diff[DiffW-1];
                    if (q_entry.kind == KIND_STRAIGHT) begin
                        mx_reg  <= st_x;
                        my_reg  <= '0;
                        rz_reg  <= '0;
                        rw_reg  <= Q30_ONE[PosW-1:0];
                        inc_reg <= 1'b0;
                    end else if (q_entry.kind != KIND_ARC) begin
                        mx_reg  <= '0;
                        my_reg  <= '0;
                        rz_reg  <= '0;
                        rw_reg  <= Q30_ONE[PosW-1:0];
                        inc_reg <= 1'b1;
                    end
                end
            end
            B_YAW: begin
                yaw_mag_reg <= div_rsp.quot;
            end
            B_SUB: begin
                // estimate is at most a few short, the remainder is fixed up below
                mrem_reg <= yaw_mag_reg - prod_reg[DivW-1:0];
            end
            B_MOD: begin
                if (mrem_reg >= TWO_PI_DIV) begin
                    mrem_reg <= mrem_reg - TWO_PI_DIV;
                end else begin
                    cx_reg   <= CORDIC_GAIN;
                    cy_reg   <= '0;
                    cz_reg   <= r_fold <<< 1;
                    flip_reg <= flip_fold;
                    step_reg <= '0;
                end
            end
            B_CORDIC: begin
                if (!cz_reg[CordW-1]) begin
                    cx_reg <= cx_reg - dx;
                    cy_reg <= cy_reg + dy;
                    cz_reg <= cz_reg - atan_v;
                end else begin
                    cx_reg <= cx_reg + dx;
                    cy_reg <= cy_reg - dy;
                    cz_reg <= cz_reg + atan_v;
                end
                step_reg <= step_reg + 1'b1;
            end
            B_FIX: begin
                s_reg <= flip_reg ? -cy_reg : cy_reg;
                c_reg <= flip_reg ? -cx_reg : cx_reg;
            end
            B_MSS: begin
                // 2*s*c / 2^30, floored
                sin_reg <= CordW'(prod_reg >>> 29);
            end
            B_RAD: begin
                omc_reg     <= CordW'(prod_reg >>> 29);
                rad_neg_reg <= rad_s[DivW];
                rad_mag_reg <= rad_s[DivW] ? DivW'(-rad_s) : DivW'(rad_s);
            end
            B_MXL: begin
                acc_reg <= prod_reg[63:0];
            end
            B_MYH: begin
                mx_arc_reg <= sat_mag(sum_r, rad_neg_reg ^ sin_reg[CordW-1]);
            end
            B_MYL: begin
                acc_reg <= prod_reg[63:0];
            end
            B_FIN: begin
                if (out_free) begin
                    mx_reg  <= mx_arc_reg;
                    my_reg  <= sat_mag(sum_r, rad_neg_reg ^ omc_reg[CordW-1]);
                    rz_reg  <= clamp_q30(s_reg);
                    rw_reg  <= clamp_q30(c_reg);
                    inc_reg <= 1'b0;
                end
            end
            default: begin
                acc_reg <= acc_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == B_IDLE && q_valid && out_free && q_entry.kind != KIND_ARC) begin
                m_valid_reg <= 1'b1;
            end else if (state_reg == B_FIN && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    a_cordic_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == B_CORDIC |-> step_reg < StepW'(CordicSteps))
        else $error("cordic step count out of range");

    a_incomplete_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && inc_reg |-> mx_reg == '0 && my_reg == '0 && rz_reg == '0)
        else $error("incomplete result carries a pose");

    a_rot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> rz_reg <= $signed(Q30_ONE[PosW-1:0])
                        && rz_reg >= -$signed(Q30_ONE[PosW-1:0]))
        else $error("rot_z beyond unit range");

    a_div_start: assert property (@(posedge aclk) disable iff (!aresetn)
        div_req.start |-> !div_rsp.busy)
        else $error("divider restarted while busy");

    a_pop_free: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop && q_entry.kind == KIND_ARC |=> state_reg == B_YAW && div_rsp.busy)
        else $error("arc step did not launch its divide");
`endif

endmodule

`default_nettype wire

// ===== src/differential_drive_odometry.sv =====
// top level of the differential drive odometry block
//
//  channel | direction | handshake             | payload
//  s_      | in        | s_valid / s_ready     | left/right position and present flags
//  m_      | out       | m_valid / m_ready     | move_x, move_y, rot_z, rot_w, incomplete
//  cfg_    | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// an incomplete or straight step is registered as a result as it leaves the queue
// an arc step makes two passes of the shared radix-2 divider
// (yaw, radius); the reciprocal-multiply angle reduction and the 30-step cordic overlap
// the radius pass
// reset is synchronous and active low; resets history, queue, sequencer, config registers
// the front keeps taking transactions while the queue has room; a stalled result blocks
// only the back end
`default_nettype none

module differential_drive_odometry #(
    parameter int QUEUE_DEPTH = ddo_pkg::QueueDepthDefault
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic signed [ddo_pkg::PosW-1:0]     s_left_position,
    input  wire logic                                s_left_present,
    input  wire logic signed [ddo_pkg::PosW-1:0]     s_right_position,
    input  wire logic                                s_right_present,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic signed [ddo_pkg::PosW-1:0]          m_move_x,
    output logic signed [ddo_pkg::PosW-1:0]          m_move_y,
    output logic signed [ddo_pkg::PosW-1:0]          m_rot_z,
    output logic signed [ddo_pkg::PosW-1:0]          m_rot_w,
    output logic                                     m_incomplete,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [ddo_pkg::CfgIdxW-1:0]         cfg_index,
    input  wire logic [ddo_pkg::CfgDataW-1:0]        cfg_data
);
    import ddo_pkg::*;

    logic [AxisW-1:0] axis_reg, axis_next;
    logic [ThrW-1:0]  thr_reg, thr_next;
    logic [AxisW-1:0] axis_eff;
    logic             q_full, q_push, q_valid, q_pop;
    ddo_entry_t       push_entry, head_entry;
    ddo_div_req_t     div_req;
    ddo_div_rsp_t     div_rsp;

    assign cfg_ready = 1'b1;
    // zero axis length behaves as one
    assign axis_eff  = (axis_reg == '0) ? AxisW'(1) : axis_reg;

    always_comb begin
        axis_next = axis_reg;
        thr_next  = thr_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_AXIS_LENGTH:        axis_next = cfg_data[AxisW-1:0];
                CFG_STRAIGHT_THRESHOLD: thr_next  = cfg_data[ThrW-1:0];
                default:                axis_next = axis_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            axis_reg <= AXIS_RESET;
            thr_reg  <= THR_RESET;
        end else begin
            axis_reg <= axis_next;
            thr_reg  <= thr_next;
        end
    end

    ddo_front u_front (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_left_position    (s_left_position),
        .s_left_present     (s_left_present),
        .s_right_position   (s_right_position),
        .s_right_present    (s_right_present),
        .straight_threshold (thr_reg),
        .q_full             (q_full),
        .q_push             (q_push),
        .q_entry            (push_entry)
    );

    ddo_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .entry_in  (push_entry),
        .full      (q_full),
        .valid     (q_valid),
        .pop       (q_pop),
        .entry_out (head_entry)
    );

    ddo_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    ddo_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .axis_eff     (axis_eff),
        .q_valid      (q_valid),
        .q_entry      (head_entry),
        .q_pop        (q_pop),
        .div_req      (div_req),
        .div_rsp      (div_rsp),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_move_x     (m_move_x),
        .m_move_y     (m_move_y),
        .m_rot_z      (m_rot_z),
        .m_rot_w      (m_rot_w),
        .m_incomplete (m_incomplete)
    );

endmodule

`default_nettype wire

// ===== sim/differential_drive_odometry_test.sv =====
// self-checking testbench for the differential drive odometry block
`timescale 1ns / 100ps

module differential_drive_odometry_test;
    import ddo_pkg::*;

    localparam logic [CfgIdxW-1:0] CFG_UNUSED = 8'd7;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int DRAIN_CYCLES = 400;
    localparam longint ONE_Q30 = 64'sd1073741824;
    localparam longint TWO_PI = 64'sd3373259426;
    localparam longint PI_HALF_TURN = 64'sd1686629713;
    localparam longint QUARTER_TURN = 64'sd843314857;
    localparam longint GAIN_Q30 = 64'sd652032874;

    typedef struct {
        logic signed [31:0] left_pos;
        logic               left_ok;
        logic signed [31:0] right_pos;
        logic               right_ok;
    } sample_t;

    typedef struct {
        logic signed [31:0] mx;
        logic signed [31:0] my;
        logic signed [31:0] rz;
        logic signed [31:0] rw;
        logic               inc;
    } pose_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [31:0] s_left_position = '0;
    logic s_left_present = 1'b0;
    logic signed [31:0] s_right_position = '0;
    logic s_right_present = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [31:0] m_move_x, m_move_y, m_rot_z, m_rot_w;
    logic m_incomplete;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CfgIdxW-1:0] cfg_index = '0;
    logic [CfgDataW-1:0] cfg_data = '0;

    sample_t sample_q[$];
    pose_t   pose_q[$];
    int      errors = 0;
    int      cycles = 0;
    int      send_idle = 0;
    int      recv_stall = 0;
    bit      in_took = 1'b0;

    // predictor state and registers
    longint          last_left, last_right;
    bit              fresh;
    logic [AxisW-1:0] axis_reg;
    logic [ThrW-1:0]  thr_reg;
    logic [31:0]      cur_l = '0, cur_r = '0;

    differential_drive_odometry uut (.*);

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("differential_drive_odometry regression: fail");
            $finish;
        end
    end

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    function automatic longint sat_word(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint clamp_unit(input longint v);
        if (v > ONE_Q30) return ONE_Q30;
        if (v < -ONE_Q30) return -ONE_Q30;
        return v;
    endfunction

    // trunc(a * b / 2^30) saturated, split to stay inside 64 bits
    function automatic longint scale_q30(input longint a, input longint b);
        bit neg;
        longint unsigned ua, ub, r;
        neg = (a < 0) != (b < 0);
        ua = (a < 0) ? -a : a;
        ub = (b < 0) ? -b : b;
        r = (((ua >> 32) * ub) << 2) + (((ua & 64'hFFFF_FFFF) * ub) >> 30);
        if (neg) return (r > 64'd2147483648) ? -64'sd2147483648 : -longint'(r);
        return (r > 64'd2147483647) ? 64'sd2147483647 : longint'(r);
    endfunction

    function automatic longint atan_step(input int i);
        longint t[30] = '{843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
                          16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
                          131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255,
                          127, 63, 31, 15, 8, 4, 2};
        return t[i];
    endfunction

    // sin/cos of a Q29 half angle, Q30 results
    task automatic half_angle_sincos(input longint h, output longint s, output longint c);
        longint r, x, y, z, dx, dy;
        bit flip;
        r = h % TWO_PI;
        flip = 1'b0;
        if (r > PI_HALF_TURN) r -= TWO_PI;
        if (r < -PI_HALF_TURN) r += TWO_PI;
        if (r > QUARTER_TURN) begin
            r -= PI_HALF_TURN;
            flip = 1'b1;
        end else if (r < -QUARTER_TURN) begin
            r += PI_HALF_TURN;
            flip = 1'b1;
        end
        x = GAIN_Q30;
        y = 0;
        z = r * 2;
        for (int i = 0; i < 30; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_step(i);
            end else begin
                x += dx; y -= dy; z += atan_step(i);
            end
        end
        s = flip ? -y : y;
        c = flip ? -x : x;
    endtask

    task automatic predict_pose(input sample_t smp, output pose_t p);
        longint dl, dr, diff, axis, yaw, s, c, sin_yaw, omc, rad, mx, my, rz, rw;
        dl = 0; dr = 0; mx = 0; my = 0; rz = 0; rw = ONE_Q30;
        axis = (axis_reg == 0) ? 1 : longint'(axis_reg);
        if (smp.left_ok) begin
            dl = longint'(smp.left_pos) - last_left;
            last_left = smp.left_pos;
        end
        if (smp.right_ok) begin
            dr = longint'(smp.right_pos) - last_right;
            last_right = smp.right_pos;
        end
        if (fresh) begin
            dl = 0; dr = 0; fresh = 0;
        end
        p.inc = !(smp.left_ok && smp.right_ok);
        if (!p.inc) begin
            diff = dr - dl;
            if (((diff < 0) ? -diff : diff) > longint'(thr_reg)) begin
                yaw = (diff * (64'sd1 << 28)) / axis;
                half_angle_sincos(yaw, s, c);
                sin_yaw = (2 * s * c) >>> 30;
                omc = (2 * s * s) >>> 30;
                rad = (yaw != 0) ? (dl * (64'sd1 << 28)) / yaw : 0;
                rad += axis >>> 1;
                mx = scale_q30(rad, sin_yaw);
                my = scale_q30(rad, omc);
                rz = clamp_unit(s);
                rw = clamp_unit(c);
            end else begin
                mx = sat_word((dl + dr) >>> 1);
            end
        end
        p.mx = mx[31:0]; p.my = my[31:0]; p.rz = rz[31:0]; p.rw = rw[31:0];
    endtask

    // monitor: predict on input transactions, check result transactions
    always @(posedge aclk) begin
        pose_t p, want;
        sample_t smp;
        in_took = aresetn && s_valid && s_ready;
        if (aresetn && cfg_valid && cfg_ready) begin
            if (cfg_index == CFG_AXIS_LENGTH) axis_reg = cfg_data[AxisW-1:0];
            else if (cfg_index == CFG_STRAIGHT_THRESHOLD) thr_reg = cfg_data[ThrW-1:0];
        end
        if (in_took) begin
            smp = '{s_left_position, s_left_present, s_right_position, s_right_present};
            predict_pose(smp, p);
            pose_q.insert(pose_q.size(), p);
        end
        if (aresetn && m_valid && m_ready) begin
            if (pose_q.size() == 0) begin
                report("unexpected transaction", 0, 0);
            end else begin
                want = pose_q.pop_front();
                if (m_move_x !== want.mx) report("move_x", m_move_x, want.mx);
                if (m_move_y !== want.my) report("move_y", m_move_y, want.my);
                if (m_rot_z !== want.rz) report("rot_z", m_rot_z, want.rz);
                if (m_rot_w !== want.rw) report("rot_w", m_rot_w, want.rw);
                if (m_incomplete !== want.inc) report("incomplete", m_incomplete, want.inc);
            end
        end
    end

    // driver
    always @(negedge aclk) begin
        sample_t smp;
        if (aresetn) begin
            if (!s_valid || in_took) begin
                if (sample_q.size() > 0 && $urandom_range(99) >= send_idle) begin
                    smp = sample_q.pop_front();
                    s_valid <= 1'b1;
                    s_left_position <= smp.left_pos;
                    s_left_present <= smp.left_ok;
                    s_right_position <= smp.right_pos;
                    s_right_present <= smp.right_ok;
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    task automatic add_sample(input logic [31:0] lp, input bit lo,
                              input logic [31:0] rp, input bit ro);
        sample_t smp;
        smp = '{lp, lo, rp, ro};
        sample_q.insert(sample_q.size(), smp);
    endtask

    function automatic logic [31:0] small_step(input int maxbits);
        logic [31:0] v;
        v = $urandom_range((32'd1 << $urandom_range(maxbits)) - 1);
        return $urandom_range(1) ? v : -v;
    endfunction

    task automatic add_random_sample();
        int pick;
        logic [31:0] dl;
        bit lo, ro;
        pick = $urandom_range(99);
        if (pick < 55) begin
            dl = small_step(20);
            cur_l += dl;
            cur_r += dl + small_step(18);
            add_sample(cur_l, 1, cur_r, 1);
        end else if (pick < 70) begin
            dl = small_step(24);
            cur_l += dl;
            cur_r += dl + small_step(7);
            add_sample(cur_l, 1, cur_r, 1);
        end else if (pick < 82) begin
            lo = $urandom_range(1);
            ro = lo ? 1'b0 : $urandom_range(1);
            cur_l += small_step(20);
            cur_r += small_step(20);
            add_sample(cur_l, lo, cur_r, ro);
        end else begin
            cur_l = $urandom;
            cur_r = $urandom;
            add_sample(cur_l, 1, cur_r, 1);
        end
    endtask

    task automatic wait_drained();
        while (sample_q.size() > 0 || s_valid || pose_q.size() > 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input int idle, input int stall, input int count);
        send_idle = idle;
        recv_stall = stall;
        repeat (count) add_random_sample();
        wait_drained();
    endtask

    initial begin
        axis_reg = AXIS_RESET;
        thr_reg = THR_RESET;
        last_left = 0;
        last_right = 0;
        fresh = 1;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: first sample with a tread missing, then extremes
        add_sample(32'h1234_5678, 1, 32'h0000_0000, 0);
        add_sample(32'h1234_0000, 1, 32'h0001_0000, 1);
        add_sample(32'h1234_0000, 0, 32'h0001_0000, 0);
        add_sample(32'h1234_0042, 1, 32'h0001_0000, 1);
        add_sample(32'h1234_0084, 1, 32'h0000_FFFF, 1);
        add_sample(32'h7FFF_FFFF, 1, 32'h7FFF_FFFF, 1);
        add_sample(32'h8000_0000, 1, 32'h8000_0000, 1);
        add_sample(32'h7FFF_FFFF, 1, 32'h7FFF_FFFF, 1);
        add_sample(32'h8000_0000, 1, 32'h7FFF_FFFF, 1);
        add_sample(32'h7FFF_FFFF, 1, 32'h8000_0000, 1);
        add_sample(32'h7FFF_FFF0, 1, 32'h8000_0000, 1);
        add_sample(32'h7FFF_FFF0, 1, 32'h8000_0100, 1);
        add_sample(32'h0000_0000, 0, 32'h8001_0000, 1);
        add_sample(32'h0001_0000, 1, 32'h8002_0000, 1);
        add_sample(32'h0001_8000, 1, 32'h8002_8000, 1);
        add_sample(32'hFFFF_FFFF, 1, 32'h0000_0000, 1);
        wait_drained();

        write_reg(CFG_AXIS_LENGTH, 32'hFFF0_0000);      // upper bits dropped: axis zero
        write_reg(CFG_STRAIGHT_THRESHOLD, 32'h0000_0000);
        write_reg(CFG_UNUSED, 32'h0000_0005);
        add_sample(32'h0000_0000, 1, 32'h0000_0001, 1);
        add_sample(32'h0000_0002, 1, 32'h0000_0001, 1);
        add_sample(32'h0100_0000, 1, 32'h0000_0001, 1);
        wait_drained();
        run_phase(0, 0, 120);

        write_reg(CFG_AXIS_LENGTH, 32'h000F_FFFF);
        write_reg(CFG_STRAIGHT_THRESHOLD, 32'h0000_FFFF);
        run_phase(73, 0, 150);

        write_reg(CFG_AXIS_LENGTH, 32'd1);
        write_reg(CFG_STRAIGHT_THRESHOLD, 32'd3);
        run_phase(0, 73, 150);

        write_reg(CFG_AXIS_LENGTH, AXIS_RESET);
        write_reg(CFG_STRAIGHT_THRESHOLD, THR_RESET);
        run_phase(19, 19, 180);

        write_reg(CFG_AXIS_LENGTH, 32'd6554);
        write_reg(CFG_STRAIGHT_THRESHOLD, 32'd1000);
        run_phase(0, 0, 150);

        write_reg(CFG_AXIS_LENGTH, 32'd131072);
        write_reg(CFG_STRAIGHT_THRESHOLD, 32'd20);
        run_phase(73, 73, 150);

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0 && pose_q.size() == 0) begin
            $display("differential_drive_odometry regression: pass");
        end else begin
            $display("differential_drive_odometry regression: fail");
        end
        $finish;
    end

endmodule
